/* rtl/core/bmsi_pkg.sv */
// Shared types and constants for the cartridge bank mapper.
`timescale 1ns / 1ps

package bmsi_pkg;

	// Request kinds carried in the action field.
	typedef enum logic [1:0] {
		ACT_CPU_READ  = 2'd0,
		ACT_CPU_WRITE = 2'd1,
		ACT_PPU_ADDR  = 2'd2
	} action_t;

	// Result regions.
	typedef enum logic [1:0] {
		REG_NONE = 2'd0,
		REG_WRAM = 2'd1,
		REG_PRG  = 2'd2,
		REG_CHR  = 2'd3
	} region_t;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		CFG_PRG_MASK = 2'd0,
		CFG_CHR_MASK = 2'd1
	} cfg_index_t;

	// Register window selected by CPU address bits 14:13.
	typedef enum logic [1:0] {
		WIN_BANK = 2'd0,
		WIN_MIRR = 2'd1,
		WIN_IRQL = 2'd2,
		WIN_IRQE = 2'd3
	} reg_window_t;

	localparam int ACTION_W = 2;
	localparam int ADDR_W = 16;
	localparam int DATA_W = 8;
	localparam int REGION_W = 2;
	localparam int TARGET_W = 21;
	localparam int CFG_IDX_W = 2;
	localparam int LOWCNT_W = 6;
	localparam int EDGE_FILTER_MIN_DEF = 30;
	localparam logic [LOWCNT_W-1:0] LOWCNT_MAX = '1;
	localparam logic [7:0] PRG_MASK_RST = 8'd63;
	localparam logic [7:0] CHR_MASK_RST = 8'd255;

endpackage

/* rtl/core/bank_mapper_with_scanline_irq.sv */
// Cartridge bank mapper with scanline interrupt counter, top level.
`timescale 1ns / 1ps

// Translates CPU reads, CPU writes and PPU address updates into a region and a
// physical address, and keeps the bank registers, mirroring bit and scanline
// interrupt counter that CPU writes to $8000-$FFFF program. Every request gives
// exactly one result. A request is taken into an input register, worked out
// against the mapper state and placed in a result register; one request can be
// accepted in every cycle while rsp_stall does not hold the result register. The
// rate is one request per clock when the result channel does not stall, set by
// the single pass from the input register to the result register. The result
// shows the IRQ line and mirroring as they stand after the request.
// Configuration writes (bank masks) are always ready and should be issued only
// while no request is in flight.
module bank_mapper_with_scanline_irq #(
	parameter int EDGE_FILTER_MIN = bmsi_pkg::EDGE_FILTER_MIN_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// Request channel
	input  logic                              req_valid,
	output logic                              req_stall,
	input  logic [bmsi_pkg::ACTION_W-1:0]     action,
	input  logic [bmsi_pkg::ADDR_W-1:0]       address,
	input  logic [bmsi_pkg::DATA_W-1:0]       write_data,
	// Result channel
	output logic                              rsp_valid,
	input  logic                              rsp_stall,
	output logic [bmsi_pkg::REGION_W-1:0]     region,
	output logic [bmsi_pkg::TARGET_W-1:0]     target_address,
	output logic                              irq_line,
	output logic                              horizontal_mirroring,
	// Configuration channel
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [bmsi_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [7:0]                        cfg_data
);
	import bmsi_pkg::*;

	localparam logic [LOWCNT_W-1:0] FILTER_MIN = LOWCNT_W'(EDGE_FILTER_MIN);

	// Input stage
	logic                valid_s1;
	logic [ACTION_W-1:0] action_s1;
	logic [ADDR_W-1:0]   address_s1;
	logic [DATA_W-1:0]   data_s1;
	logic                advance;

	// Configuration and mapper state
	logic [7:0]          prg_mask_q;
	logic [7:0]          chr_mask_q;
	logic [7:0]          bank_sel_q;
	logic [7:0]          bank_q [8];
	logic                mirror_q;
	logic [7:0]          irq_latch_q;
	logic [7:0]          irq_count_q;
	logic                irq_reload_q;
	logic                irq_en_q;
	logic                irq_asserted_q;
	logic                last_a12_q;
	logic [LOWCNT_W-1:0] low_cnt_q;

	// Next-state values
	logic [7:0]          bank_sel_d;
	logic                bank_we;
	logic [2:0]          bank_wsel;
	logic                mirror_d;
	logic [7:0]          irq_latch_d;
	logic [7:0]          irq_count_d;
	logic                irq_reload_d;
	logic                irq_en_d;
	logic                irq_asserted_d;
	logic                last_a12_d;
	logic [LOWCNT_W-1:0] low_cnt_d;

	// Result computation
	logic [REGION_W-1:0] region_d;
	logic [TARGET_W-1:0] target_d;
	logic [13:0]         ppu_addr;
	logic [2:0]          chr_slot;
	logic [7:0]          chr_bank;
	logic [7:0]          chr_reg;
	logic [7:0]          prg_bank;
	logic [1:0]          prg_slot;
	logic                a12;

	// Result register
	logic                rsp_valid_q;
	logic [REGION_W-1:0] region_q;
	logic [TARGET_W-1:0] target_q;
	logic                irq_line_q;
	logic                mirror_out_q;

	assign advance   = !rsp_valid_q || !rsp_stall;
	assign req_stall = valid_s1 && !advance;
	assign cfg_ready = 1'b1;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!req_stall && req_valid) begin
			action_s1  <= action;
			address_s1 <= address;
			data_s1    <= write_data;
		end
	end

	// PRG translation: four 8K slots, bit 6 of bank select swaps slots 0 and 2.
	assign prg_slot = address_s1[14:13];
	always_comb begin
		if (prg_slot == 2'd1) begin
			prg_bank = bank_q[7] & prg_mask_q;
		end else if (prg_slot == 2'd3) begin
			prg_bank = prg_mask_q;
		end else if ((prg_slot == 2'd0) != bank_sel_q[6]) begin
			prg_bank = bank_q[6] & prg_mask_q;
		end else begin
			prg_bank = {prg_mask_q[7:1], 1'b0};
		end
	end

	// CHR translation: two 2K pairs and four 1K banks, bit 7 swaps the halves.
	assign ppu_addr = address_s1[13:0];
	assign a12      = ppu_addr[12];
	assign chr_slot = ppu_addr[12:10] ^ {bank_sel_q[7], 2'b00};
	always_comb begin
		if (!chr_slot[2]) begin
			chr_reg  = bank_q[{2'b00, chr_slot[1]}];
			chr_bank = {chr_reg[7:1], chr_slot[0]} & chr_mask_q;
		end else begin
			chr_reg  = bank_q[3'(chr_slot - 3'd2)];
			chr_bank = chr_reg & chr_mask_q;
		end
	end

	// Result and next state for the request in the input register.
	always_comb begin
		logic [7:0] cnt_tmp;
		cnt_tmp        = irq_count_q;
		region_d       = REG_NONE;
		target_d       = '0;
		bank_sel_d     = bank_sel_q;
		bank_we        = 1'b0;
		bank_wsel      = bank_sel_q[2:0];
		mirror_d       = mirror_q;
		irq_latch_d    = irq_latch_q;
		irq_count_d    = irq_count_q;
		irq_reload_d   = irq_reload_q;
		irq_en_d       = irq_en_q;
		irq_asserted_d = irq_asserted_q;
		last_a12_d     = last_a12_q;
		low_cnt_d      = low_cnt_q;
		case (action_t'(action_s1))
			ACT_CPU_READ, ACT_CPU_WRITE: begin
				if (address_s1[15:13] == 3'b011) begin
					region_d = REG_WRAM;
					target_d = {8'd0, address_s1[12:0]};
				end else if (address_s1[15]) begin
					if (action_t'(action_s1) == ACT_CPU_READ) begin
						region_d = REG_PRG;
						target_d = {prg_bank, address_s1[12:0]};
					end else begin
						case (reg_window_t'(address_s1[14:13]))
							WIN_BANK: begin
								if (address_s1[0]) begin
									bank_we = 1'b1;
								end else begin
									bank_sel_d = data_s1;
								end
							end
							WIN_MIRR: begin
								if (!address_s1[0]) begin
									mirror_d = data_s1[0];
								end
							end
							WIN_IRQL: begin
								if (address_s1[0]) begin
									irq_count_d  = 8'd0;
									irq_reload_d = 1'b1;
								end else begin
									irq_latch_d = data_s1;
								end
							end
							WIN_IRQE: begin
								irq_en_d = address_s1[0];
								if (!address_s1[0]) begin
									irq_asserted_d = 1'b0;
								end
							end
							default: begin
							end
						endcase
					end
				end
			end
			ACT_PPU_ADDR: begin
				// A12 edge filter and scanline counter.
				if (!last_a12_q && a12) begin
					if (low_cnt_q > FILTER_MIN) begin
						if (irq_count_q == 8'd0 || irq_reload_q) begin
							cnt_tmp = irq_latch_q;
						end else begin
							cnt_tmp = irq_count_q - 8'd1;
						end
						irq_count_d  = cnt_tmp;
						irq_reload_d = 1'b0;
						if (cnt_tmp == 8'd0 && irq_en_q) begin
							irq_asserted_d = 1'b1;
						end
					end
					low_cnt_d = '0;
				end
				if (!a12 && low_cnt_q != LOWCNT_MAX) begin
					low_cnt_d = low_cnt_q + LOWCNT_W'(1);
				end
				last_a12_d = a12;
				if (!ppu_addr[13]) begin
					region_d = REG_CHR;
					target_d = {3'd0, chr_bank, ppu_addr[9:0]};
				end
			end
			default: begin
			end
		endcase
	end

	// Mapper state and configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prg_mask_q     <= PRG_MASK_RST;
			chr_mask_q     <= CHR_MASK_RST;
			bank_sel_q     <= '0;
			for (int i = 0; i < 7; i++) begin
				bank_q[i] <= '0;
			end
			bank_q[7]      <= 8'd1;
			mirror_q       <= 1'b0;
			irq_latch_q    <= '0;
			irq_count_q    <= '0;
			irq_reload_q   <= 1'b0;
			irq_en_q       <= 1'b0;
			irq_asserted_q <= 1'b0;
			last_a12_q     <= 1'b0;
			low_cnt_q      <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index_t'(cfg_index) == CFG_PRG_MASK) begin
					prg_mask_q <= cfg_data;
				end else if (cfg_index_t'(cfg_index) == CFG_CHR_MASK) begin
					chr_mask_q <= cfg_data;
				end
			end
			if (valid_s1 && advance) begin
				bank_sel_q     <= bank_sel_d;
				if (bank_we) begin
					bank_q[bank_wsel] <= data_s1;
				end
				mirror_q       <= mirror_d;
				irq_latch_q    <= irq_latch_d;
				irq_count_q    <= irq_count_d;
				irq_reload_q   <= irq_reload_d;
				irq_en_q       <= irq_en_d;
				irq_asserted_q <= irq_asserted_d;
				last_a12_q     <= last_a12_d;
				low_cnt_q      <= low_cnt_d;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			region_q     <= region_d;
			target_q     <= target_d;
			irq_line_q   <= irq_asserted_d;
			mirror_out_q <= mirror_d;
		end
	end

	assign rsp_valid            = rsp_valid_q;
	assign region               = region_q;
	assign target_address       = target_q;
	assign irq_line             = irq_line_q;
	assign horizontal_mirroring = mirror_out_q;

`ifndef NO_ASSERTIONS
	// The interrupt line only rises while interrupts are enabled.
	a_irq_needs_enable: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(irq_asserted_q) |-> $past(irq_en_q))
		else $error("irq asserted while disabled");

	// The request channel stalls only while the input register holds a request.
	a_stall_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> valid_s1)
		else $error("stall with empty input register");

	// A PPU update with A12 high leaves the low-update count at zero.
	a_a12_high_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance && action_s1 == ACT_PPU_ADDR && address_s1[12])
		|=> low_cnt_q == '0)
		else $error("low-update count not cleared");

	// A result with no region carries a zero address.
	a_none_zero_target: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && region_q == REG_NONE) |-> target_q == '0)
		else $error("nonzero address without region");
`endif

endmodule

/* verif/bank_mapper_with_scanline_irq_tb.sv */
// Self-checking testbench for the cartridge bank mapper with scanline interrupt counter.
`timescale 1ns / 1ps

module bank_mapper_with_scanline_irq_tb;
	import bmsi_pkg::*;

	// Action code outside the defined set; the mapper must treat it as a no-op.
	localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
	// Cycles to let pass after the last result before the block counts as idle.
	localparam int SETTLE_CYCLES = 4;

	typedef struct packed {
		region_t               region;
		logic [TARGET_W-1:0]   target;
		logic                  irq;
		logic                  hmirror;
	} mapping_t;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  req_valid = 1'b0;
	logic                  req_stall;
	logic [ACTION_W-1:0]   action = '0;
	logic [ADDR_W-1:0]     address = '0;
	logic [DATA_W-1:0]     write_data = '0;
	logic                  rsp_valid;
	logic                  rsp_stall = 1'b0;
	logic [REGION_W-1:0]   region;
	logic [TARGET_W-1:0]   target_address;
	logic                  irq_line;
	logic                  horizontal_mirroring;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [7:0]            cfg_data = '0;

	int send_idle_pct = 0;
	int stall_pct = 0;
	int mismatch_count = 0;

	// Expected translations, oldest first.
	mapping_t pending_maps [$];

	// Shadow copy of the mapper state and bank masks.
	logic [7:0]          shadow_prg_mask;
	logic [7:0]          shadow_chr_mask;
	logic [7:0]          shadow_bank_select;
	logic [7:0]          shadow_bank [8];
	logic [7:0]          shadow_irq_latch;
	logic [7:0]          shadow_irq_count;
	logic                shadow_mirror;
	logic                shadow_reload;
	logic                shadow_irq_en;
	logic                shadow_irq_on;
	logic                shadow_last_a12;
	logic [LOWCNT_W-1:0] shadow_low_count;

	bank_mapper_with_scanline_irq dut (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("bank_mapper_with_scanline_irq verification failed");
		$finish;
	end

	function automatic void reset_shadow();
		shadow_prg_mask = PRG_MASK_RST;
		shadow_chr_mask = CHR_MASK_RST;
		shadow_bank_select = '0;
		for (int i = 0; i < 8; i++)
			shadow_bank[i] = '0;
		shadow_bank[7] = 8'd1;
		shadow_irq_latch = '0;
		shadow_irq_count = '0;
		shadow_mirror = 1'b0;
		shadow_reload = 1'b0;
		shadow_irq_en = 1'b0;
		shadow_irq_on = 1'b0;
		shadow_last_a12 = 1'b0;
		shadow_low_count = '0;
	endfunction

	// Applies one request to the shadow state and returns the translation it should give.
	function automatic mapping_t translate_request(input logic [ACTION_W-1:0] act,
			input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
		mapping_t res;
		logic [13:0] ppu;
		logic [7:0] bank;
		logic [2:0] slot;
		res.region = REG_NONE;
		res.target = '0;
		case (act)
			ACT_CPU_READ, ACT_CPU_WRITE: begin
				if (addr[15:13] == 3'b011) begin
					res.region = REG_WRAM;
					res.target = {8'd0, addr[12:0]};
				end else if (addr[15]) begin
					if (act == ACT_CPU_READ) begin
						// Four 8K slots; bit 6 of bank select swaps the first and third.
						case (addr[14:13])
							2'd1: bank = shadow_bank[7] & shadow_prg_mask;
							2'd3: bank = shadow_prg_mask;
							default: bank = ((addr[14:13] == 2'd0) != shadow_bank_select[6]) ?
								(shadow_bank[6] & shadow_prg_mask) : (shadow_prg_mask & 8'hFE);
						endcase
						res.region = REG_PRG;
						res.target = {bank, addr[12:0]};
					end else begin
						// Register write; the window is picked by address bits 14:13.
						case (reg_window_t'(addr[14:13]))
							WIN_BANK: begin
								if (addr[0])
									shadow_bank[shadow_bank_select[2:0]] = data;
								else
									shadow_bank_select = data;
							end
							WIN_MIRR: begin
								if (!addr[0])
									shadow_mirror = data[0];
							end
							WIN_IRQL: begin
								if (addr[0]) begin
									shadow_irq_count = '0;
									shadow_reload = 1'b1;
								end else begin
									shadow_irq_latch = data;
								end
							end
							default: begin
								shadow_irq_en = addr[0];
								if (!addr[0])
									shadow_irq_on = 1'b0;
							end
						endcase
					end
				end
			end
			ACT_PPU_ADDR: begin
				ppu = addr[13:0];
				// A filtered rising edge of A12 decrements or reloads the scanline counter.
				if (!shadow_last_a12 && ppu[12]) begin
					if (shadow_low_count > EDGE_FILTER_MIN_DEF) begin
						if (shadow_irq_count == 0 || shadow_reload)
							shadow_irq_count = shadow_irq_latch;
						else
							shadow_irq_count--;
						if (shadow_irq_count == 0 && shadow_irq_en)
							shadow_irq_on = 1'b1;
						shadow_reload = 1'b0;
					end
					shadow_low_count = '0;
				end
				if (!ppu[12] && shadow_low_count != LOWCNT_MAX)
					shadow_low_count++;
				shadow_last_a12 = ppu[12];
				// Pattern table space maps to eight 1K CHR slots.
				if (!ppu[13]) begin
					slot = ppu[12:10] ^ {shadow_bank_select[7], 2'b00};
					if (!slot[2])
						bank = slot[0] ? (shadow_bank[slot[1]] | 8'h01) :
							(shadow_bank[slot[1]] & 8'hFE);
					else
						bank = shadow_bank[slot - 3'd2];
					res.region = REG_CHR;
					res.target = {3'b000, bank & shadow_chr_mask, ppu[9:0]};
				end
			end
			default: ;
		endcase
		res.irq = shadow_irq_on;
		res.hmirror = shadow_mirror;
		return res;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t: %s mismatch, got 0x%0h, expected 0x%0h", $time, what, got, want);
		mismatch_count++;
	endtask

	// Receiver stalls at random.
	always @(negedge clk)
		rsp_stall <= ($urandom_range(0, 99) < stall_pct);

	// Compare each accepted result with the oldest expected translation.
	always @(posedge clk) begin : check_results
		mapping_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_maps.size() == 0) begin
				report_mismatch("result with no request outstanding", 32'(region), 32'd0);
			end else begin
				want = pending_maps.pop_front();
				if (region !== want.region)
					report_mismatch("region", 32'(region), 32'(want.region));
				if (target_address !== want.target)
					report_mismatch("target_address", 32'(target_address),
						32'(want.target));
				if (irq_line !== want.irq)
					report_mismatch("irq_line", 32'(irq_line), 32'(want.irq));
				if (horizontal_mirroring !== want.hmirror)
					report_mismatch("horizontal_mirroring", 32'(horizontal_mirroring),
						32'(want.hmirror));
			end
		end
	end

	// Sends one request after a random gap; returns at a falling edge with valid still high.
	task automatic send_request(input logic [ACTION_W-1:0] act, input logic [ADDR_W-1:0] addr,
			input logic [DATA_W-1:0] data);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		action <= act;
		address <= addr;
		write_data <= data;
		do
			@(posedge clk);
		while (req_stall);
		pending_maps.push_back(translate_request(act, addr, data));
		@(negedge clk);
	endtask

	// Holds off new requests until every expected result has come back.
	task automatic wait_for_results();
		req_valid <= 1'b0;
		@(negedge clk);
		while (pending_maps.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Writes both bank masks back to back; the block must be idle.
	task automatic program_masks(input logic [7:0] prg, input logic [7:0] chr);
		cfg_valid <= 1'b1;
		for (int i = 0; i < 2; i++) begin
			cfg_index <= (i == 0) ? CFG_PRG_MASK : CFG_CHR_MASK;
			cfg_data <= (i == 0) ? prg : chr;
			do
				@(posedge clk);
			while (!cfg_ready);
			if (i == 0)
				shadow_prg_mask = prg;
			else
				shadow_chr_mask = chr;
			@(negedge clk);
		end
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	function automatic logic [ADDR_W-1:0] window_address(input reg_window_t win, input logic odd);
		logic [ADDR_W-1:0] a;
		a = ADDR_W'($urandom);
		a[15] = 1'b1;
		a[14:13] = win;
		a[0] = odd;
		return a;
	endfunction

	function automatic logic [ADDR_W-1:0] ppu_address(input logic a12);
		logic [ADDR_W-1:0] a;
		a = ADDR_W'($urandom);
		a[12] = a12;
		return a;
	endfunction

	// Mixed request with random fields, weighted toward PPU address updates.
	task automatic send_random_request();
		logic [ACTION_W-1:0] act;
		logic [ADDR_W-1:0] addr;
		int pick;
		pick = $urandom_range(0, 99);
		addr = ADDR_W'($urandom);
		if (pick < 30) begin
			act = ACT_CPU_READ;
		end else if (pick < 60) begin
			act = ACT_CPU_WRITE;
			if (pick < 52)
				addr[15] = 1'b1;
		end else if (pick < 95) begin
			act = ACT_PPU_ADDR;
		end else begin
			act = ACT_UNUSED;
		end
		send_request(act, addr, 8'($urandom));
	endtask

	// Address decode at reset state: unmapped, work RAM, PRG, CHR, nametables, unused action.
	task automatic test_cpu_decode();
		send_request(ACT_CPU_READ, 16'h0000, 8'h00);
		send_request(ACT_CPU_WRITE, 16'h5FFF, 8'hFF);
		send_request(ACT_CPU_READ, 16'h6000, 8'h00);
		send_request(ACT_CPU_WRITE, 16'h7FFF, 8'hFF);
		send_request(ACT_CPU_READ, 16'h8000, 8'h00);
		send_request(ACT_CPU_READ, 16'hA000, 8'h00);
		send_request(ACT_CPU_READ, 16'hC000, 8'h00);
		send_request(ACT_CPU_READ, 16'hFFFF, 8'hFF);
		send_request(ACT_PPU_ADDR, 16'h0000, 8'h00);
		send_request(ACT_PPU_ADDR, 16'h1FFF, 8'h00);
		send_request(ACT_PPU_ADDR, 16'h2000, 8'h00);
		send_request(ACT_PPU_ADDR, 16'hFFFF, 8'hFF);
		send_request(ACT_UNUSED, 16'hFFFF, 8'hFF);
	endtask

	// Bank switching in both PRG and CHR modes, and the mirroring register.
	task automatic test_bank_switching();
		send_request(ACT_CPU_WRITE, 16'h8000, 8'hC6);
		send_request(ACT_CPU_WRITE, 16'h8001, 8'hFF);
		send_request(ACT_CPU_READ, 16'h8000, 8'h00);
		send_request(ACT_CPU_READ, 16'hC000, 8'h00);
		send_request(ACT_PPU_ADDR, 16'h1C00, 8'h00);
		send_request(ACT_CPU_WRITE, 16'h8000, 8'h07);
		send_request(ACT_CPU_WRITE, 16'h8001, 8'hFF);
		send_request(ACT_CPU_READ, 16'hBFFF, 8'h00);
		send_request(ACT_CPU_WRITE, 16'h8000, 8'h00);
		send_request(ACT_CPU_WRITE, 16'h8001, 8'hFF);
		send_request(ACT_PPU_ADDR, 16'h0400, 8'h00);
		send_request(ACT_PPU_ADDR, 16'h03FF, 8'h00);
		send_request(ACT_CPU_WRITE, 16'hA000, 8'hFF);
		send_request(ACT_CPU_WRITE, 16'hA001, 8'h00);
		send_request(ACT_CPU_WRITE, 16'hA002, 8'h00);
	endtask

	// Scanline-like PPU fetch patterns around the A12 filter threshold, with some noise.
	task automatic test_scanline_irq(input int lines);
		int lows;
		int pick;
		send_request(ACT_CPU_WRITE, window_address(WIN_IRQL, 1'b0),
			($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3)));
		send_request(ACT_CPU_WRITE, window_address(WIN_IRQL, 1'b1), 8'($urandom));
		send_request(ACT_CPU_WRITE, window_address(WIN_IRQE, $urandom_range(0, 4) != 0),
			8'($urandom));
		repeat (lines) begin
			pick = $urandom_range(0, 99);
			if (pick < 70)
				lows = $urandom_range(31, 34);
			else if (pick < 85)
				lows = $urandom_range(20, 30);
			else
				lows = $urandom_range(35, 80);
			repeat (lows) begin
				if ($urandom_range(0, 11) == 0)
					send_random_request();
				else
					send_request(ACT_PPU_ADDR, ppu_address(1'b0), 8'($urandom));
			end
			repeat ($urandom_range(1, 3))
				send_request(ACT_PPU_ADDR, ppu_address(1'b1), 8'($urandom));
			// Occasionally acknowledge the interrupt and re-enable it.
			if ($urandom_range(0, 5) == 0) begin
				send_request(ACT_CPU_WRITE, window_address(WIN_IRQE, 1'b0), 8'($urandom));
				send_request(ACT_CPU_WRITE, window_address(WIN_IRQE, 1'b1), 8'($urandom));
			end
		end
	endtask

	task automatic test_random_traffic(input int count);
		repeat (count) begin
			if ($urandom_range(0, 39) == 0)
				wait_for_results();
			send_random_request();
		end
	endtask

	initial begin
		reset_shadow();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		send_idle_pct = 24;
		stall_pct = 74;
		test_cpu_decode();
		test_bank_switching();
		for (int blk = 0; blk < 6; blk++) begin
			if (blk == 2) begin
				send_idle_pct = 74;
				stall_pct = 24;
			end
			if (blk == 4) begin
				send_idle_pct = 0;
				stall_pct = 0;
			end
			wait_for_results();
			case (blk)
				0: program_masks(8'hFF, 8'hFF);
				1: program_masks(8'h00, 8'h00);
				2: program_masks(8'h0F, 8'h7F);
				3: program_masks(8'($urandom), 8'($urandom));
				4: program_masks(8'h01, 8'hFE);
				default: program_masks(8'hFF, 8'h00);
			endcase
			test_scanline_irq(2);
			test_random_traffic(20);
		end
		wait_for_results();
		if (mismatch_count == 0)
			$display("bank_mapper_with_scanline_irq verification clean");
		else
			$display("bank_mapper_with_scanline_irq verification failed");
		$finish;
	end

endmodule
